/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// Needs a clk and an active-low rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QWTN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qwtn assertion failed");

// Next-cycle implication, checked outside reset.
`define QWTN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qwtn assertion failed");

`endif

/* hw/rtl/qwtn_pkg.sv */
// Package of the quadratic wave table normaliser: widths, constants and the
// divider request and response types. Depends on nothing.
package qwtn_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = 6;
  localparam int CODE_W     = 10;
  localparam int COEF_W     = 32;
  localparam int RAW_W      = 34;
  localparam int PROD_W     = 49;
  localparam int DVD_W      = RAW_W + CODE_W;
  localparam int CNT_W      = 4;

  localparam logic [CODE_W-1:0] DAC_MID = CODE_W'(512);
  localparam logic [15:0]       Q_MAX   = 16'hFFFF;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [RAW_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CODE_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/quadratic_wave_table_normalizer.sv */
// Top level of the quadratic wave table normaliser.
// Depends on qwtn_pkg, qwtn_ram and qwtn_div.

// One input word carries a, b and c in signed Q16.16. The block evaluates
// y = a*x*x + b*x + c at TABLE_SIZE points spread evenly over [0, 1] (x = 1
// is clamped to 0xFFFF), stores the raw samples in a RAM and tracks their
// minimum and maximum, then sends TABLE_SIZE output words in table order,
// each a 10-bit code floor((y-min)*1023/(max-min)), or 512 with tuser set
// when the wave is flat. tlast marks the final entry. Evaluation steps
// through states S_M0 to S_M3 for each entry on one shared 32 by 17
// multiplier; normalisation is paced by the RAM read, any output stall and
// the serial divider that yields one quotient bit per cycle. A new word is
// taken only once the previous table has been handed to the output register.
module quadratic_wave_table_normalizer #(
  parameter int TABLE_SIZE = qwtn_pkg::TABLE_SIZE
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // entry_index [5:0], dac_code [15:6]
  output logic        out_tuser,  // flat_wave [0]
  output logic        out_tlast
);

  localparam int AW    = $clog2(TABLE_SIZE);
  localparam int XSTEP = 65536 / (TABLE_SIZE - 1);
  localparam int XREM  = 65536 % (TABLE_SIZE - 1);
  localparam int CW    = qwtn_pkg::COEF_W;
  localparam int RW    = qwtn_pkg::RAW_W;
  localparam int IW    = qwtn_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_RD, S_LD, S_DIV, S_OUT
  } state_t;

  state_t                       state_r;
  logic signed [CW-1:0]         a_r, b_r, c_r, ax_r, bx_r;
  logic signed [qwtn_pkg::PROD_W-1:0] prod_r;
  logic [16:0]                  x_r;
  logic [IW:0]                  xr_r;
  logic [IW-1:0]                idx_r;
  logic signed [RW-1:0]         min_r, max_r;
  logic [qwtn_pkg::CODE_W-1:0]  code_r;
  logic                         out_valid_r;
  logic [IW-1:0]                out_idx_r;
  logic [qwtn_pkg::CODE_W-1:0]  out_code_r;
  logic                         out_flat_r;
  logic                         out_last_r;

  logic [15:0]                  xq;
  logic signed [CW-1:0]         mul_op;
  logic signed [qwtn_pkg::PROD_W-1:0] prod_nxt;
  logic signed [RW-1:0]         y;
  logic [IW:0]                  xr_sum;
  logic                         is_last;
  logic                         flat;
  logic [RW-1:0]                span;
  logic [RW-1:0]                offset;
  logic [RW-1:0]                rdata;
  logic                         out_free;
  qwtn_pkg::div_req_t           div_req;
  qwtn_pkg::div_rsp_t           div_rsp;

  assign xq      = x_r[16] ? qwtn_pkg::Q_MAX : x_r[15:0];
  assign is_last = (idx_r == IW'(TABLE_SIZE - 1));

  always_comb begin
    case (state_r)
      S_M0:    mul_op = a_r;
      S_M1:    mul_op = b_r;
      default: mul_op = ax_r;
    endcase
  end

  assign prod_nxt = mul_op * $signed({1'b0, xq});
  assign y = RW'($signed(prod_r[47:16])) + RW'(bx_r) + RW'(c_r);
  assign xr_sum = xr_r + (IW+1)'(XREM);

  assign flat   = (max_r == min_r);
  assign span   = max_r - min_r;
  assign offset = rdata - min_r;

  // Dividend is offset * 1023, formed as offset * 1024 - offset.
  assign div_req.start    = (state_r == S_LD) && !flat;
  assign div_req.dividend = {offset, (qwtn_pkg::CODE_W)'(0)} - qwtn_pkg::DVD_W'(offset);
  assign div_req.divisor  = span;

  assign out_free = !out_valid_r || out_tready;

  qwtn_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (state_r == S_M3),
    .waddr(idx_r[AW-1:0]),
    .wdata(y),
    .raddr(idx_r[AW-1:0]),
    .rdata(rdata)
  );

  qwtn_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            a_r     <= in_tdata[31:0];
            b_r     <= in_tdata[63:32];
            c_r     <= in_tdata[95:64];
            x_r     <= '0;
            xr_r    <= '0;
            idx_r   <= '0;
            state_r <= S_M0;
          end
        end
        S_M0: begin
          prod_r  <= prod_nxt;
          state_r <= S_M1;
        end
        S_M1: begin
          ax_r    <= prod_r[47:16];
          prod_r  <= prod_nxt;
          state_r <= S_M2;
        end
        S_M2: begin
          bx_r    <= prod_r[47:16];
          prod_r  <= prod_nxt;
          state_r <= S_M3;
        end
        S_M3: begin
          if (idx_r == '0 || y > max_r) begin
            max_r <= y;
          end
          if (idx_r == '0 || y < min_r) begin
            min_r <= y;
          end
          // Step x by 65536/(TABLE_SIZE-1), carrying the remainder exactly.
          if (xr_sum >= (IW+1)'(TABLE_SIZE - 1)) begin
            xr_r <= xr_sum - (IW+1)'(TABLE_SIZE - 1);
            x_r  <= x_r + 17'(XSTEP + 1);
          end else begin
            xr_r <= xr_sum;
            x_r  <= x_r + 17'(XSTEP);
          end
          if (is_last) begin
            idx_r   <= '0;
            state_r <= S_RD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_M0;
          end
        end
        S_RD: begin
          state_r <= S_LD;
        end
        S_LD: begin
          if (flat) begin
            code_r  <= qwtn_pkg::DAC_MID;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            code_r  <= div_rsp.quot;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_idx_r   <= idx_r;
            out_code_r  <= code_r;
            out_flat_r  <= flat;
            out_last_r  <= is_last;
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_code_r, out_idx_r};
  assign out_tuser  = out_flat_r;
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/qwtn_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module qwtn_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/qwtn_div.sv */
// Restoring divider giving a 10-bit quotient, one bit per cycle.
// Depends on qwtn_pkg; the quotient is known to fit in 10 bits.
module qwtn_div (
  input  logic              clk,
  input  logic              rst_n,
  input  qwtn_pkg::div_req_t req,
  output qwtn_pkg::div_rsp_t rsp
);

  logic [qwtn_pkg::DVD_W-1:0]  rem_r;
  logic [qwtn_pkg::DVD_W-1:0]  dsh_r;
  logic [qwtn_pkg::CODE_W-1:0] quot_r;
  logic [qwtn_pkg::CNT_W-1:0]  cnt_r;
  logic                        done_r;
  logic                        fits;

  assign fits = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r <= req.dividend;
        // The divisor starts aligned under the top quotient bit.
        dsh_r <= {req.divisor, (qwtn_pkg::CODE_W)'(0)} >> 1;
        quot_r <= '0;
        cnt_r <= qwtn_pkg::CNT_W'(qwtn_pkg::CODE_W);
      end else if (cnt_r != '0) begin
        if (fits) begin
          rem_r <= rem_r - dsh_r;
        end
        quot_r <= {quot_r[qwtn_pkg::CODE_W-2:0], fits};
        dsh_r  <= dsh_r >> 1;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == qwtn_pkg::CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

/* hw/rtl/qwtn_checker.sv */
// Port-level checker for the quadratic wave table normaliser, bound to the
// top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module qwtn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A stalled output word holds its payload.
  `QWTN_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // No new request is taken while a table is still partly delivered.
  `QWTN_ASSERT_IMP(a_busy, out_tvalid && !out_tlast, !in_tready)

  // A flat wave always carries the mid-scale code.
  `QWTN_ASSERT_IMP(a_flat_mid, out_tvalid && out_tuser, out_tdata[15:6] == 10'd512)

endmodule

bind quadratic_wave_table_normalizer qwtn_checker u_qwtn_checker (.*);
